[hdl/urx_pkg.sv]
`timescale 1ns / 1ps

package urx_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } urx_op_e;

  // configuration register indexes
  localparam logic [1:0] CFG_BIT_PERIOD    = 2'd0;
  localparam logic [1:0] CFG_BUFFER_LENGTH = 2'd1;

  // frame receiver status for the item just taken
  typedef struct packed {
    logic       done;
    logic [7:0] value;
    logic       busy;
  } urx_frame_t;

endpackage

[hdl/uart_rx_8n1_ring_buffer_top.sv]
`timescale 1ns / 1ps

// the ring memory read register adds the item stage; the output register follows it
// throughput: one item per cycle unless the result channel stalls
// reset (async, active low): receiver idle, write index, fill count, flag and
// valids cleared, bit period 16 and buffer length 256
// ring contents are not cleared: entries at or above the fill count read as zero,
// so neither reset nor a clear item needs a pass over the memory
module uart_rx_8n1_ring_buffer_top #(
  parameter int BUFFER_DEPTH = 256,
  parameter int PERIOD_WIDTH = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  // configuration
  input  logic                                          cfg_we_i,
  input  logic [1:0]                                    cfg_idx_i,
  input  logic [(PERIOD_WIDTH > 9 ? PERIOD_WIDTH : 9)-1:0] cfg_data_i,
  // item channel
  input  logic                                          in_valid_i,
  output logic                                          in_stall_o,
  input  logic [1:0]                                    opcode_i,
  input  logic                                          rx_line_i,
  input  logic [7:0]                                    read_index_i,
  // result channel
  output logic                                          out_valid_o,
  input  logic                                          out_stall_i,
  output logic                                          byte_done_o,
  output logic [7:0]                                    byte_value_o,
  output logic [7:0]                                    write_position_o,
  output logic                                          data_ready_o,
  output logic [7:0]                                    read_value_o,
  output logic                                          busy_res_o
);
  import urx_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int LW = $clog2(BUFFER_DEPTH + 1);

  // result fields between the item stage and the output register
  typedef struct packed {
    logic       done;
    logic [7:0] value;
    logic [7:0] wpos;
    logic       ready;
    logic       busy;
    logic       rd_hit;
  } res_t;

  // configuration registers
  logic [PERIOD_WIDTH-1:0] bit_period_q;
  logic [8:0]              buffer_length_q;
  logic [PERIOD_WIDTH-1:0] period_eff;
  logic [31:0]             len32;
  logic [LW-1:0]           len_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q    <= PERIOD_WIDTH'(16);
      buffer_length_q <= 9'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BIT_PERIOD:    bit_period_q    <= cfg_data_i[PERIOD_WIDTH-1:0];
        CFG_BUFFER_LENGTH: buffer_length_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // a period below two acts as two, length clamps to one .. depth
  assign period_eff = (bit_period_q < PERIOD_WIDTH'(2)) ? PERIOD_WIDTH'(2) : bit_period_q;
  assign len32      = {23'd0, buffer_length_q};
  always_comb begin
    if (len32 == 32'd0) begin
      len_eff = LW'(1);
    end else if (len32 > 32'(BUFFER_DEPTH)) begin
      len_eff = LW'(BUFFER_DEPTH);
    end else begin
      len_eff = LW'(len32);
    end
  end

  // item beat decode
  urx_op_e op;
  logic    in_acc, tick_en, clear_en, rd_en;

  assign op       = urx_op_e'(opcode_i);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign tick_en  = in_acc && (op == OP_TICK);
  assign clear_en = in_acc && (op == OP_CLEAR);
  assign rd_en    = in_acc && (op == OP_READ);

  // frame receiver
  urx_frame_t frm;

  urx_frame #(
    .PERIOD_WIDTH(PERIOD_WIDTH)
  ) u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick_en),
    .clear_i (clear_en),
    .line_i  (rx_line_i),
    .period_i(period_eff),
    .status_o(frm)
  );

  // ring write side; writes always run upward from entry zero after a clear,
  // so the written entries form a prefix tracked by fill_q
  logic [AW-1:0] widx_q, widx_d;
  logic [LW-1:0] fill_q, fill_d, widx_inc;
  logic          ready_q, ready_d;
  logic          store_en;
  logic [31:0]   widx32;

  assign store_en = frm.done;
  assign widx_inc = LW'(widx_q) + LW'(1);

  always_comb begin
    widx_d  = widx_q;
    fill_d  = fill_q;
    ready_d = ready_q;
    if (clear_en) begin
      widx_d  = '0;
      fill_d  = '0;
      ready_d = 1'b0;
    end else if (store_en) begin
      widx_d  = (widx_inc >= len_eff) ? '0 : widx_inc[AW-1:0];
      ready_d = 1'b1;
      if (widx_inc > fill_q) begin
        fill_d = widx_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q  <= '0;
      fill_q  <= '0;
      ready_q <= 1'b0;
    end else begin
      widx_q  <= widx_d;
      fill_q  <= fill_d;
      ready_q <= ready_d;
    end
  end

  assign widx32 = 32'(widx_d);

  // ring memory, one write and one registered read port
  logic [7:0]    ring_mem [BUFFER_DEPTH];
  logic [7:0]    rd_data_q;
  logic [31:0]   ridx32;
  logic [AW-1:0] rd_addr;
  logic          rd_hit;

  assign ridx32  = {24'd0, read_index_i};
  assign rd_addr = ridx32[AW-1:0];
  assign rd_hit  = rd_en && (ridx32 < 32'(fill_q));

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      ring_mem[widx_q] <= frm.value;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[rd_addr];
    end
  end

  // item stage: holds the fields while the memory read completes
  res_t s1_q, s1_d;
  logic s1_valid_q;
  logic s1_adv;

  assign s1_d.done   = frm.done;
  assign s1_d.value  = frm.value;
  assign s1_d.wpos   = widx32[7:0];
  assign s1_d.ready  = ready_d;
  assign s1_d.busy   = frm.busy;
  assign s1_d.rd_hit = rd_hit;

  // the stage moves on whenever the output register is empty or being drained
  assign s1_adv     = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      byte_done_o      <= s1_q.done;
      byte_value_o     <= s1_q.value;
      write_position_o <= s1_q.wpos;
      data_ready_o     <= s1_q.ready;
      busy_res_o       <= s1_q.busy;
      // a miss or a non-read beat returns zero
      read_value_o     <= s1_q.rd_hit ? rd_data_q : 8'd0;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // write index never runs ahead of the written prefix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(widx_q) <= fill_q)
    else $error("write index beyond fill count");

  // a clear beat empties the ring on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_en |=> (fill_q == '0) && (widx_q == '0) && !ready_q)
    else $error("clear did not empty the ring");

  // a stored byte always carries the ready flag with it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_q.done |-> s1_q.ready)
    else $error("byte stored without ready flag");

  // the item stage never drops a held beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_q))
    else $error("held item stage changed");
`endif

endmodule

[hdl/urx_frame.sv]
`timescale 1ns / 1ps

module urx_frame #(
  parameter int PERIOD_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    tick_i,
  input  logic                    clear_i,
  input  logic                    line_i,
  input  logic [PERIOD_WIDTH-1:0] period_i,
  output urx_pkg::urx_frame_t     status_o
);
  import urx_pkg::*;

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_FIRST    = 4'd1;
  localparam logic [3:0] PH_LAST_BIT = 4'd8;

  logic [3:0]            phase_q, phase_d;
  logic [PERIOD_WIDTH:0] tick_q, tick_d, tick_dec, period_ext;
  logic [7:0]            shift_q, shift_d;
  logic [2:0]            bit_idx;
  logic                  done;
  logic [7:0]            value;

  assign period_ext = {1'b0, period_i};
  assign tick_dec   = (tick_q != '0) ? tick_q - 1'b1 : tick_q;
  assign bit_idx    = 3'(phase_q - PH_FIRST);

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    shift_d = shift_q;
    done    = 1'b0;
    value   = 8'd0;
    if (tick_i) begin
      if (phase_q == PH_IDLE) begin
        if (!line_i) begin
          // start edge: centre of data bit 0 is one and a half periods away
          phase_d = PH_FIRST;
          shift_d = 8'd0;
          tick_d  = (period_ext >> 1) + period_ext;
        end
      end else begin
        tick_d = tick_dec;
        if (tick_dec == '0) begin
          if (phase_q <= PH_LAST_BIT) begin
            shift_d[bit_idx] = line_i;
            phase_d          = phase_q + 4'd1;
            tick_d           = period_ext;
          end else begin
            done    = 1'b1;
            value   = shift_q;
            phase_d = PH_IDLE;
            tick_d  = '0;
          end
        end
      end
    end else if (clear_i) begin
      shift_d = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      shift_q <= 8'd0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      shift_q <= shift_d;
    end
  end

  assign status_o.done  = done;
  assign status_o.value = value;
  assign status_o.busy  = (phase_d != PH_IDLE);

endmodule
